// ----- sv/gbt_pkg.sv -----
// Shared types and constants for the graph traversal block.
// Request and result structs, operation codes, register defaults.
// No dependencies.
package gbt_pkg;

    localparam int VERT_W           = 4;
    localparam int OP_W             = 3;
    localparam int CFG_W            = 5;
    localparam int DEF_MAX_VERTICES = 16;

    localparam logic [CFG_W-1:0] CFG_VERTEX_COUNT_RST = 5'd16;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_BFS    = 3'd3;
    localparam logic [OP_W-1:0] OP_DFS    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
    } gbt_req_t;

    typedef struct packed {
        logic [VERT_W-1:0] visited_vertex;
        logic              edge_present;
        logic              last;
    } gbt_rsp_t;

endpackage

// ----- sv/gbt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while read enable is low. No dependencies.
module gbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/graph_bfs_dfs_traversal.sv -----
// Top level of the graph traversal block: adjacency matrix, work list, sequencer.
// Depends on gbt_pkg and gbt_ram.
//
// Undirected graph held as an adjacency bit matrix in a RAM (one row per vertex),
// with edge add / remove / query requests and breadth-first or depth-first
// traversal from vertex 0. The block handles one request at a time and raises
// in_stall while it works; a finished result sits in the output register, so the
// next request is taken while that result waits. Add and remove do a
// read-modify-write of both symmetric rows (one RAM port each way); a query
// reads row a, then loads its result into the output slot. A traversal does
// a setup, then for each popped vertex a work-list read, a row read and a scan
// of the n active columns, where n is the active vertex count; the scan pushes
// at most one vertex per cycle through the single write port of the work list.
// A final empty pop ends the walk and the last result follows. Results are
// emitted in pop order, last set on the final one; a stalled output holds the
// sequencer. Matrix rows read as zero until first written (per-row valid
// flags), so no clearing pass follows reset.
// vertex_count: 0 acts as 1, values above MAX_VERTICES act as MAX_VERTICES.
module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gbt_pkg::gbt_req_t         in_data,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output gbt_pkg::gbt_rsp_t         out_data,
    // vertex_count register write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gbt_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);       // vertex index width
    localparam int CW = $clog2(MAX_VERTICES + 1);   // counts 0..MAX_VERTICES
    localparam int VW = gbt_pkg::VERT_W;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_EDGE_RD_A = 12'b0000_0000_0010,
        S_EDGE_WR_A = 12'b0000_0000_0100,
        S_EDGE_RD_B = 12'b0000_0000_1000,
        S_EDGE_WR_B = 12'b0000_0001_0000,
        S_QUERY_RD  = 12'b0000_0010_0000,
        S_QUERY_OUT = 12'b0000_0100_0000,
        S_TRV_INIT  = 12'b0000_1000_0000,
        S_TRV_POP   = 12'b0001_0000_0000,
        S_TRV_FETCH = 12'b0010_0000_0000,
        S_TRV_SCAN  = 12'b0100_0000_0000,
        S_TRV_END   = 12'b1000_0000_0000
    } state_t;

    // control state
    state_t                    state_reg,     state_next;
    logic                      remove_reg,    remove_next;   // edge op clears bits
    logic                      dfs_reg,       dfs_next;      // traversal uses stack
    logic                      ok_reg,        ok_next;       // endpoints in range
    logic [CW-1:0]             head_reg,      head_next;
    logic [CW-1:0]             tail_reg,      tail_next;
    logic [CW-1:0]             scan_reg,      scan_next;
    logic                      have_prev_reg, have_prev_next;
    logic [MAX_VERTICES-1:0]   seen_reg,      seen_next;     // pushed at least once
    logic [MAX_VERTICES-1:0]   row_vld_reg,   row_vld_next;  // matrix row written
    logic                      rd_vld_reg,    rd_vld_next;   // valid flag of last row read
    logic [gbt_pkg::CFG_W-1:0] vcount_reg,    vcount_next;
    logic                      out_valid_reg, out_valid_next;

    // payload
    logic [VW-1:0]             a_reg,         a_next;
    logic [VW-1:0]             b_reg,         b_next;
    logic [AW-1:0]             prev_reg,      prev_next;     // last popped vertex
    gbt_pkg::gbt_rsp_t         out_data_reg,  out_data_next;

    // RAM ports
    logic                      adj_we, adj_re;
    logic [AW-1:0]             adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0]   adj_wdata, adj_rdata, adj_row;
    logic                      wl_we, wl_re;
    logic [AW-1:0]             wl_waddr, wl_raddr;
    logic [AW-1:0]             wl_wdata, wl_rdata;

    logic                      in_ok;
    logic                      out_free;
    logic                      out_load;
    gbt_pkg::gbt_rsp_t         out_load_data;
    logic [CW-1:0]             n_active;
    logic [CW-1:0]             col;
    logic [AW-1:0]             col_idx;
    logic [MAX_VERTICES-1:0]   mask_a, mask_b;
    logic [CW-1:0]             pop_addr;

    gbt_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gbt_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_VERTICES)
    ) u_work_ram (
        .clk   (clk),
        .we    (wl_we),
        .waddr (wl_waddr),
        .wdata (wl_wdata),
        .re    (wl_re),
        .raddr (wl_raddr),
        .rdata (wl_rdata)
    );

    // Never-written rows read as zero.
    assign adj_row = rd_vld_reg ? adj_rdata : '0;

    assign in_ok = (int'(in_data.vertex_a) < MAX_VERTICES) &&
                   (int'(in_data.vertex_b) < MAX_VERTICES);

    assign mask_a = ROW_ONE << a_reg;
    assign mask_b = ROW_ONE << b_reg;

    // Active vertex count, clamped to 1..MAX_VERTICES.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_active = CW'(1);
        end
        else if (int'(vcount_reg) > MAX_VERTICES)
        begin
            n_active = CW'(MAX_VERTICES);
        end
        else
        begin
            n_active = CW'(vcount_reg);
        end
    end

    // BFS scans upward, DFS scans downward (stack pops lowest first).
    assign col      = dfs_reg ? (n_active - CW'(1) - scan_reg) : scan_reg;
    assign col_idx  = col[AW-1:0];
    assign pop_addr = dfs_reg ? (tail_reg - CW'(1)) : head_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        remove_next    = remove_reg;
        dfs_next       = dfs_reg;
        ok_next        = ok_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        have_prev_next = have_prev_reg;
        seen_next      = seen_reg;
        row_vld_next   = row_vld_reg;
        rd_vld_next    = rd_vld_reg;
        vcount_next    = vcount_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prev_next      = prev_reg;

        adj_we    = 1'b0;
        adj_waddr = '0;
        adj_wdata = '0;
        adj_re    = 1'b0;
        adj_raddr = '0;
        wl_we     = 1'b0;
        wl_waddr  = '0;
        wl_wdata  = '0;
        wl_re     = 1'b0;
        wl_raddr  = '0;

        out_load      = 1'b0;
        out_load_data = '0;

        if (cfg_valid && cfg_ready)
        begin
            vcount_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next      = in_data.vertex_a;
                    b_next      = in_data.vertex_b;
                    ok_next     = in_ok;
                    remove_next = (in_data.operation == gbt_pkg::OP_REMOVE);
                    dfs_next    = (in_data.operation == gbt_pkg::OP_DFS);
                    case (in_data.operation)
                        gbt_pkg::OP_ADD,
                        gbt_pkg::OP_REMOVE:
                        begin
                            if (in_ok)
                            begin
                                state_next = S_EDGE_RD_A;
                            end
                        end
                        gbt_pkg::OP_QUERY:
                        begin
                            state_next = S_QUERY_RD;
                        end
                        gbt_pkg::OP_BFS,
                        gbt_pkg::OP_DFS:
                        begin
                            state_next = S_TRV_INIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;   // unused codes dropped
                        end
                    endcase
                end
            end

            S_EDGE_RD_A:
            begin
                adj_re     = 1'b1;
                adj_raddr  = AW'(a_reg);
                state_next = S_EDGE_WR_A;
            end

            S_EDGE_WR_A:
            begin
                adj_we     = 1'b1;
                adj_waddr  = AW'(a_reg);
                adj_wdata  = remove_reg ? (adj_row & ~mask_b) : (adj_row | mask_b);
                state_next = S_EDGE_RD_B;
            end

            // row b read after row a is written, so a self loop sees its own update
            S_EDGE_RD_B:
            begin
                adj_re     = 1'b1;
                adj_raddr  = AW'(b_reg);
                state_next = S_EDGE_WR_B;
            end

            S_EDGE_WR_B:
            begin
                adj_we     = 1'b1;
                adj_waddr  = AW'(b_reg);
                adj_wdata  = remove_reg ? (adj_row & ~mask_a) : (adj_row | mask_a);
                state_next = S_IDLE;
            end

            S_QUERY_RD:
            begin
                adj_re     = 1'b1;
                adj_raddr  = AW'(a_reg);
                state_next = S_QUERY_OUT;
            end

            S_QUERY_OUT:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_load_data.edge_present = ok_reg && (|(adj_row & mask_b));
                    out_load_data.last         = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            // clear marks, push vertex 0
            S_TRV_INIT:
            begin
                wl_we          = 1'b1;
                wl_waddr       = '0;
                wl_wdata       = '0;
                seen_next      = ROW_ONE;
                head_next      = '0;
                tail_next      = CW'(1);
                have_prev_next = 1'b0;
                state_next     = S_TRV_POP;
            end

            // head == tail is empty for both queue and stack (stack head stays 0)
            S_TRV_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_TRV_END;
                end
                else
                begin
                    wl_re    = 1'b1;
                    wl_raddr = pop_addr[AW-1:0];
                    if (dfs_reg)
                    begin
                        tail_next = tail_reg - CW'(1);
                    end
                    else
                    begin
                        head_next = head_reg + CW'(1);
                    end
                    state_next = S_TRV_FETCH;
                end
            end

            // popped vertex ready: emit the previous one, fetch this row
            S_TRV_FETCH:
            begin
                if (!have_prev_reg || out_free)
                begin
                    if (have_prev_reg)
                    begin
                        out_load                     = 1'b1;
                        out_load_data.visited_vertex = VW'(prev_reg);
                    end
                    adj_re         = 1'b1;
                    adj_raddr      = wl_rdata;
                    prev_next      = wl_rdata;
                    have_prev_next = 1'b1;
                    scan_next      = '0;
                    state_next     = S_TRV_SCAN;
                end
            end

            // one column per cycle, at most one push
            S_TRV_SCAN:
            begin
                if (adj_row[col_idx] && !seen_reg[col_idx])
                begin
                    wl_we              = 1'b1;
                    wl_waddr           = tail_reg[AW-1:0];
                    wl_wdata           = col_idx;
                    tail_next          = tail_reg + CW'(1);
                    seen_next[col_idx] = 1'b1;
                end
                if (scan_reg == n_active - CW'(1))
                begin
                    state_next = S_TRV_POP;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end

            S_TRV_END:
            begin
                if (out_free)
                begin
                    out_load                     = 1'b1;
                    out_load_data.visited_vertex = VW'(prev_reg);
                    out_load_data.last           = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adj_we)
        begin
            row_vld_next[adj_waddr] = 1'b1;
        end
        if (adj_re)
        begin
            rd_vld_next = row_vld_reg[adj_raddr];
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_load_data;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            out_data_next  = out_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            remove_reg    <= 1'b0;
            dfs_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            have_prev_reg <= 1'b0;
            seen_reg      <= '0;
            row_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            vcount_reg    <= gbt_pkg::CFG_VERTEX_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remove_reg    <= remove_next;
            dfs_reg       <= dfs_next;
            ok_reg        <= ok_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_reg      <= scan_next;
            have_prev_reg <= have_prev_next;
            seen_reg      <= seen_next;
            row_vld_reg   <= row_vld_next;
            rd_vld_reg    <= rd_vld_next;
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- tb/traversal_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the graph traversal block: a mirror of the adjacency matrix and
// the vertex_count register, and the queue of results that the requests imply.
// Depends on gbt_pkg.
package traversal_scoreboard_pkg;

    import gbt_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;

    class traversal_scoreboard;

        logic [NV-1:0]    adj_rows [NV];
        logic [CFG_W-1:0] vertex_count;
        gbt_rsp_t         pending_results [$];
        int               failures;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            vertex_count = CFG_VERTEX_COUNT_RST;
            failures     = 0;
        endfunction

        function void set_vertex_count(logic [CFG_W-1:0] value);
            vertex_count = value;
        endfunction

        // zero acts as one, anything past the matrix size as the full size
        function int active_vertices();
            if (vertex_count == 0)
                return 1;
            if (vertex_count > NV)
                return NV;
            return int'(vertex_count);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Walk from vertex 0; vertices are marked when pushed.
        // Depth-first pushes in descending order so the lowest pops first.
        function void predict_walk(bit depth_first);
            logic [VERT_W-1:0] work [NV];
            logic [NV-1:0]     discovered;
            logic [VERT_W-1:0] pop_order [$];
            logic [VERT_W-1:0] node;
            gbt_rsp_t          rsp;
            int                n;
            int                head;
            int                tail;
            int                j;
            int                col;

            n          = active_vertices();
            discovered = '0;
            discovered[0] = 1'b1;
            work[0]    = '0;
            head       = 0;
            tail       = 1;
            while (tail > head)
            begin
                if (depth_first)
                begin
                    tail--;
                    node = work[tail];
                end
                else
                begin
                    node = work[head];
                    head++;
                end
                pop_order.push_back(node);
                for (j = 0; j < n; j++)
                begin
                    col = depth_first ? (n - 1 - j) : j;
                    if (adj_rows[node][col] && !discovered[col] && tail < NV)
                    begin
                        work[tail]      = VERT_W'(col);
                        discovered[col] = 1'b1;
                        tail++;
                    end
                end
            end
            foreach (pop_order[i])
            begin
                rsp.visited_vertex = pop_order[i];
                rsp.edge_present   = 1'b0;
                rsp.last           = (i == pop_order.size() - 1);
                pending_results.push_back(rsp);
            end
        endfunction

        function void note_request(gbt_req_t req);
            gbt_rsp_t rsp;
            case (req.operation)
                OP_ADD:
                begin
                    adj_rows[req.vertex_a][req.vertex_b] = 1'b1;
                    adj_rows[req.vertex_b][req.vertex_a] = 1'b1;
                end
                OP_REMOVE:
                begin
                    adj_rows[req.vertex_a][req.vertex_b] = 1'b0;
                    adj_rows[req.vertex_b][req.vertex_a] = 1'b0;
                end
                OP_QUERY:
                begin
                    rsp.visited_vertex = '0;
                    rsp.edge_present   = adj_rows[req.vertex_a][req.vertex_b];
                    rsp.last           = 1'b1;
                    pending_results.push_back(rsp);
                end
                OP_BFS:  predict_walk(1'b0);
                OP_DFS:  predict_walk(1'b1);
                default: ;
            endcase
        endfunction

        function void check_result(gbt_rsp_t got);
            gbt_rsp_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: visited_vertex %0d edge_present %0b last %0b",
                       got.visited_vertex, got.edge_present, got.last);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.visited_vertex !== want.visited_vertex)
            begin
                $error("visited_vertex: expected %0d, actual %0d",
                       want.visited_vertex, got.visited_vertex);
                failures++;
            end
            if (got.edge_present !== want.edge_present)
            begin
                $error("edge_present: expected %0b, actual %0b",
                       want.edge_present, got.edge_present);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                failures++;
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the graph traversal testbench: clock, reset, request and result drivers.
// Depends on gbt_pkg, traversal_scoreboard_pkg and graph_bfs_dfs_traversal.
module tb_top;

    import gbt_pkg::*;
    import traversal_scoreboard_pkg::*;

    // codes 5..7 are spare: the block must drop them silently
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // add/remove produce no result, so after the last result we give the
    // block this long to finish them before touching vertex_count
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 50;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    gbt_req_t         in_data;
    logic             out_valid;
    logic             out_stall;
    gbt_rsp_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    traversal_scoreboard book;
    // when set, neither side idles: back-to-back requests, no output stall
    bit               quiet;

    graph_bfs_dfs_traversal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length used by both sides: mostly none, sometimes a few cycles,
    // now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly endpoints the traversals will scan, so walks go deep; the rest
    // anywhere in the matrix, including rows past vertex_count.
    function automatic logic [VERT_W-1:0] pick_vertex();
        if ($urandom_range(0, 99) < 85)
            return VERT_W'($urandom_range(0, book.active_vertices() - 1));
        return VERT_W'($urandom_range(0, DEF_MAX_VERTICES - 1));
    endfunction

    function automatic gbt_req_t random_request();
        gbt_req_t req;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 48)
            req.operation = OP_ADD;
        else if (r < 63)
            req.operation = OP_REMOVE;
        else if (r < 78)
            req.operation = OP_QUERY;
        else if (r < 88)
            req.operation = OP_BFS;
        else if (r < 98)
            req.operation = OP_DFS;
        else
            req.operation = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        req.vertex_a = pick_vertex();
        req.vertex_b = pick_vertex();
        return req;
    endfunction

    // One request: optional idle gap, then hold valid and payload until the
    // block drops its stall at a rising edge.
    task automatic send_request(input gbt_req_t req);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        book.note_request(req);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int a, input int b);
        gbt_req_t req;
        req.operation = op;
        req.vertex_a  = VERT_W'(a);
        req.vertex_b  = VERT_W'(b);
        send_request(req);
    endtask

    // Sender holds off until every predicted result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Drain, then let any trailing add/remove finish so the block is idle.
    task automatic drain_and_settle();
        wait_results_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [CFG_W-1:0] value);
        drain_and_settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_vertex_count(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall bursts, changed on the falling edge only.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if ($urandom_range(0, 99) < 30)
                hold = pick_gap();
            out_stall <= (hold > 0);
        end
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(out_data);
    end

    // Hard stop: several times the slowest legal run (every request a full
    // 16-vertex walk with long stalls on every result).
    initial
    begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_counts [PHASES];

        book      = new();
        quiet     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = CFG_VERTEX_COUNT_RST;

        // extremes first, then odd sizes, then full size, then anything
        phase_counts[0] = 5'd31;
        phase_counts[1] = 5'd0;
        phase_counts[2] = 5'd1;
        phase_counts[3] = 5'd2;
        phase_counts[4] = 5'd7;
        phase_counts[5] = CFG_W'($urandom_range(3, 15));
        phase_counts[6] = 5'd16;
        phase_counts[7] = CFG_W'($urandom_range(0, 31));

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset vertex_count of 16.
        // Empty matrix: queries answer 0, walks emit vertex 0 alone.
        send_op(OP_QUERY, 0, 0);
        send_op(OP_QUERY, 15, 15);
        send_op(OP_BFS, 0, 0);
        send_op(OP_DFS, 15, 15);
        // a small graph with a self loop and the highest vertex
        send_op(OP_ADD, 0, 15);
        send_op(OP_ADD, 0, 3);
        send_op(OP_ADD, 3, 3);
        send_op(OP_ADD, 15, 7);
        send_op(OP_ADD, 1, 0);
        send_op(OP_QUERY, 15, 0);
        send_op(OP_QUERY, 3, 3);
        send_op(OP_QUERY, 7, 3);
        send_op(OP_BFS, 0, 0);
        send_op(OP_DFS, 0, 0);
        // spare codes: no result, matrix untouched
        send_op(OP_SPARE_FIRST, 15, 15);
        send_op(OP_SPARE_FIRST + 3'd1, 0, 15);
        send_op(OP_SPARE_LAST, 15, 0);
        // removal is symmetric too
        send_op(OP_REMOVE, 15, 0);
        send_op(OP_QUERY, 0, 15);
        send_op(OP_REMOVE, 3, 3);
        send_op(OP_QUERY, 3, 3);
        send_op(OP_BFS, 0, 0);
        send_op(OP_DFS, 0, 0);

        // Random phases, one vertex_count each, some with no idling at all.
        for (int p = 0; p < PHASES; p++)
        begin
            write_vertex_count(phase_counts[p]);
            quiet = (p % 3 == 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // sender holds off mid-phase until the pipeline is empty
                if (i == ITEMS_PER_PHASE / 2 && p % 2 == 0)
                    wait_results_drained();
                send_request(random_request());
            end
        end

        quiet = 1'b0;
        drain_and_settle();
        if (book.failures == 0 && book.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/gbt_pkg.sv
sv/gbt_ram.sv
sv/graph_bfs_dfs_traversal.sv
tb/traversal_scoreboard_pkg.sv
tb/tb_top.sv
